/* rtl/shm64_pkg.sv */
`timescale 1ns / 1ps
package shm64_pkg;

  localparam logic [63:0] MixMulA   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB   = 64'h94d049bb133111eb;
  localparam int unsigned MixShiftA = 30;
  localparam int unsigned MixShiftB = 27;
  localparam int unsigned MixShiftC = 31;

  // partial product selection for the 64x64 low-half multiply
  localparam logic [1:0] MUL_LL = 2'd0;
  localparam logic [1:0] MUL_LH = 2'd1;
  localparam logic [1:0] MUL_HL = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_MIXB = 5'b00100,
    S_FIN  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       const_b;
    logic       add_en;
    logic       add_hi;
    logic       clr_p;
    logic       mix_b;
    logic       fin;
    logic       emit;
  } dp_cmd_t;

endpackage

/* rtl/set_hash_mix64_accumulator.sv */
`timescale 1ns / 1ps
// item carrying a member: the next item is taken only once its mixing is done,
// which takes two 64-bit multiplies, each three 32x32 partial products on one shared multiplier
// item without member or mark: taken without stall; end of set passes an emit state that waits for a free output
// result sits in an output register, held until taken; input stalls while a member is mixed and at end of set
// asynchronous active-low reset clears accumulator, count, state and output valid
module set_hash_mix64_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] element_i,
  input  logic        has_element_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] set_hash_o
);
  import shm64_pkg::*;

  dp_cmd_t cmd;
  logic    out_free;

  shm64_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .has_element_i (has_element_i),
    .last_i        (last_i),
    .out_free_i    (out_free),
    .in_ready_o    (in_ready_o),
    .cmd_o         (cmd)
  );

  shm64_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .element_i   (element_i),
    .out_ready_i (out_ready_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .set_hash_o  (set_hash_o)
  );

endmodule

/* rtl/shm64_dp.sv */
`timescale 1ns / 1ps
module shm64_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  shm64_pkg::dp_cmd_t cmd_i,
  input  logic [31:0]       element_i,
  input  logic              out_ready_i,
  output logic              out_free_o,
  output logic              out_valid_o,
  output logic [63:0]       set_hash_o
);
  import shm64_pkg::*;

  logic [63:0] v_q, v_d;
  logic [63:0] m_q;
  logic [63:0] p_q, p_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] cnt_q, cnt_d;
  logic [63:0] hash_q;
  logic        valid_q, valid_d;

  logic [63:0] x_ext;
  logic [63:0] k;
  logic [31:0] mul_a, mul_b;

  assign x_ext = {{32{element_i[31]}}, element_i};
  assign k     = cmd_i.const_b ? MixMulB : MixMulA;

  always_comb begin
    mul_a = v_q[31:0];
    mul_b = k[31:0];
    case (cmd_i.mul_sel)
      MUL_LL: begin
        mul_a = v_q[31:0];
        mul_b = k[31:0];
      end
      MUL_LH: begin
        mul_a = v_q[31:0];
        mul_b = k[63:32];
      end
      MUL_HL: begin
        mul_a = v_q[63:32];
        mul_b = k[31:0];
      end
      default: begin
        mul_a = v_q[31:0];
        mul_b = k[31:0];
      end
    endcase
  end

  always_comb begin
    v_d = v_q;
    if (cmd_i.load) begin
      v_d = x_ext ^ (x_ext >> MixShiftA);
    end else if (cmd_i.mix_b) begin
      v_d = p_q ^ (p_q >> MixShiftB);
    end
  end

  // cross terms only reach the upper half of the low 64 bits
  always_comb begin
    p_d = p_q;
    if (cmd_i.clr_p) begin
      p_d = '0;
    end else if (cmd_i.add_en) begin
      if (cmd_i.add_hi) begin
        p_d = {p_q[63:32] + m_q[31:0], p_q[31:0]};
      end else begin
        p_d = p_q + m_q;
      end
    end
  end

  always_comb begin
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (cmd_i.fin) begin
      acc_d = acc_q ^ (p_q ^ (p_q >> MixShiftC));
      cnt_d = cnt_q + 64'd1;
    end else if (cmd_i.emit) begin
      acc_d   = '0;
      cnt_d   = '0;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    p_q <= p_d;
    if (cmd_i.mul_en) begin
      m_q <= {32'd0, mul_a} * {32'd0, mul_b};
    end
    if (cmd_i.emit) begin
      hash_q <= cnt_q ^ acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  assign out_free_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign set_hash_o  = hash_q;

endmodule

/* rtl/shm64_ctrl.sv */
`timescale 1ns / 1ps
module shm64_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               has_element_i,
  input  logic               last_i,
  input  logic               out_free_i,
  output logic               in_ready_o,
  output shm64_pkg::dp_cmd_t cmd_o
);
  import shm64_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       phase_q, phase_d;
  logic       last_q, last_d;
  logic       in_xfer;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    phase_d = phase_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.const_b = phase_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (has_element_i) begin
            cmd_o.load = 1'b1;
            phase_d    = 1'b0;
            step_d     = 2'd0;
            last_d     = last_i;
            state_d    = S_MUL;
          end else if (last_i) begin
            state_d = S_EMIT;
          end
        end
      end
      S_MUL: begin
        // issue partial products; each is added from the product register
        cmd_o.mul_en = (step_q != 2'd3);
        cmd_o.clr_p  = (step_q == 2'd0);
        cmd_o.add_en = (step_q != 2'd0);
        cmd_o.add_hi = step_q[1];
        case (step_q)
          2'd0:    cmd_o.mul_sel = MUL_LL;
          2'd1:    cmd_o.mul_sel = MUL_LH;
          2'd2:    cmd_o.mul_sel = MUL_HL;
          default: cmd_o.mul_sel = MUL_LL;
        endcase
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = phase_q ? S_FIN : S_MIXB;
        end
      end
      S_MIXB: begin
        cmd_o.mix_b = 1'b1;
        phase_d     = 1'b1;
        step_d      = 2'd0;
        state_d     = S_MUL;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = last_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= 2'd0;
      phase_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      last_q  <= last_d;
    end
  end

endmodule

/* rtl/shm64_checker.sv */
`timescale 1ns / 1ps
module shm64_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        has_element_i,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] set_hash_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(set_hash_o))
    else $error("result changed while stalled");

  a_busy_after_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && has_element_i |=> !in_ready_o)
    else $error("input taken while a member is being mixed");

  a_idle_item_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !has_element_i && !last_i |=> in_ready_o)
    else $error("empty item stalled the input");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an end of set");

endmodule

bind set_hash_mix64_accumulator shm64_checker u_shm64_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .has_element_i (has_element_i),
  .last_i        (last_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .set_hash_o    (set_hash_o)
);

/* tb/sv/tb_set_hash_mix64_accumulator.sv */
`timescale 1ns / 1ps
module tb_set_hash_mix64_accumulator;

  localparam logic [63:0] MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MUL_B   = 64'h94d049bb133111eb;
  localparam int unsigned SHIFT_A = 30;
  localparam int unsigned SHIFT_B = 27;
  localparam int unsigned SHIFT_C = 31;

  localparam int unsigned ITEM_TARGET  = 1850;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned N_DIRECTED   = 20;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_EVERY3
  } rx_mode_e;

  typedef struct packed {
    logic [31:0] element;
    logic        has_element;
    logic        last;
    logic        fixed_ok;
    logic [63:0] fixed_hash;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] element_i;
  logic        has_element_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] set_hash_o;

  // typed-in expectation travelling with the payload
  logic        fixed_ok_q;
  logic [63:0] fixed_hash_q;

  logic [63:0] hash_expect_q[$];
  logic [63:0] mix_sum;
  logic [63:0] member_total;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  logic [31:0] prev_member;
  bit          hold_off_req;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 64'd0},
    '{32'hdead_beef, 1'b0, 1'b0, 1'b0, 64'd0},
    '{32'hffff_ffff, 1'b0, 1'b1, 1'b1, 64'd0},
    '{32'h0000_0000, 1'b1, 1'b1, 1'b1, 64'd1},
    '{32'h7fff_ffff, 1'b1, 1'b0, 1'b0, 64'd0},
    '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 64'd0},
    '{32'hffff_ffff, 1'b1, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0001, 1'b1, 1'b0, 1'b0, 64'd0},
    '{32'h5a5a_a5a5, 1'b0, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 64'd0},
    '{32'h1234_5678, 1'b1, 1'b0, 1'b0, 64'd0},
    '{32'h1234_5678, 1'b1, 1'b1, 1'b1, 64'd2},
    '{32'h8000_0000, 1'b1, 1'b1, 1'b0, 64'd0},
    '{32'h7fff_ffff, 1'b1, 1'b1, 1'b0, 64'd0},
    '{32'hffff_ffff, 1'b1, 1'b1, 1'b0, 64'd0},
    '{32'hffff_ffff, 1'b1, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 64'd0},
    '{32'hcafe_f00d, 1'b0, 1'b0, 1'b0, 64'd0},
    '{32'haaaa_5555, 1'b1, 1'b0, 1'b0, 64'd0},
    '{32'h5555_aaaa, 1'b0, 1'b1, 1'b0, 64'd0}
  };

  set_hash_mix64_accumulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .element_i     (element_i),
    .has_element_i (has_element_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .set_hash_o    (set_hash_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] mix_member(input logic [31:0] member);
    logic [63:0] v;
    v = {{32{member[31]}}, member};
    v = (v ^ (v >> SHIFT_A)) * MUL_A;
    v = (v ^ (v >> SHIFT_B)) * MUL_B;
    v = v ^ (v >> SHIFT_C);
    return v;
  endfunction

  // result side checked before the input side, a result never stems from the same edge
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hash_expect_q.size() == 0) begin
        $error("unexpected result: set_hash actual %h", set_hash_o);
        fail_count++;
      end else begin
        want = hash_expect_q.pop_front();
        if (set_hash_o !== want) begin
          $error("mismatch on set_hash: expected %h actual %h", want, set_hash_o);
          fail_count++;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (has_element_i) begin
        mix_sum      = mix_sum ^ mix_member(element_i);
        member_total = member_total + 64'd1;
      end
      if (last_i) begin
        hash_expect_q.push_back(fixed_ok_q ? fixed_hash_q : (member_total ^ mix_sum));
        mix_sum      = '0;
        member_total = '0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: segments of different stall patterns, plus one long hold-off on request
  initial begin
    rx_mode_e    mode;
    int unsigned seg_left;
    int unsigned phase;
    out_ready_i = 1'b0;
    seg_left    = 0;
    phase       = 0;
    mode        = RX_FREE;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_e'(2'($urandom_range(0, 3)));
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        phase++;
        case (mode)
          RX_FREE:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= (phase % 3 == 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic [31:0] member, input logic has, input logic lst,
                           input logic ok, input logic [63:0] hash);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    element_i     <= member;
    has_element_i <= has;
    last_i        <= lst;
    fixed_ok_q    <= ok;
    fixed_hash_q  <= hash;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [31:0] pick_member();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 15));
      3:       return 32'(-int'($urandom_range(1, 16)));
      4:       return prev_member;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_for_results();
    while (hash_expect_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned items_sent;
    int unsigned set_size;
    int unsigned pick;
    bit          close_on_member;
    bit          hold_done;
    bit          pause_done;
    logic [31:0] member;
    logic        lst;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    element_i     = '0;
    has_element_i = 1'b0;
    last_i        = 1'b0;
    fixed_ok_q    = 1'b0;
    fixed_hash_q  = '0;
    mix_sum       = '0;
    member_total  = '0;
    fail_count    = 0;
    cycle_count   = 0;
    burst_left    = 0;
    prev_member   = '0;
    hold_off_req  = 1'b0;
    items_sent    = 0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].element, directed_rows[i].has_element, directed_rows[i].last,
                directed_rows[i].fixed_ok, directed_rows[i].fixed_hash);
    end
    wait_for_results();

    // sets of random size with stray empty items, members either closing the set or followed by an end marker
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) set_size = 0;
      else if (pick == 1) set_size = $urandom_range(9, 16);
      else set_size = $urandom_range(1, 6);
      close_on_member = (set_size > 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned k = 0; k < set_size; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item($urandom, 1'b0, 1'b0, 1'b0, '0);
          items_sent++;
        end
        member = pick_member();
        prev_member = member;
        lst = close_on_member && (k == set_size - 1);
        send_item(member, 1'b1, lst, 1'b0, '0);
        items_sent++;
      end
      if (!close_on_member) begin
        send_item($urandom, 1'b0, 1'b1, 1'b0, '0);
        items_sent++;
      end
      if (!hold_done && items_sent >= 600) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && items_sent >= 1200) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        wait_for_results();
        pause_done = 1'b1;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
